@@ rtl/dfe_pkg.sv @@
package dfe_pkg;

    // depth of the log2 lookup table
    localparam int LOG_TABLE_DEPTH = 64;
    localparam int LOG_IDX_W       = $clog2(LOG_TABLE_DEPTH);

    // register indexes (one 32-bit word per register)
    localparam logic REG_IDX_BASE_THRESHOLD = 1'b0;
    localparam logic [15:0] BASE_THRESHOLD_RESET = 16'd624;

    // wetness limits: wet when 5*g < 1.0, clamp to 0.001 below 66
    localparam logic [15:0] WET_LIMIT   = 16'd13107;
    localparam logic [15:0] CLAMP_LIMIT = 16'd66;

    // fixed point constants
    localparam logic [30:0] LOG10_2_Q32      = 31'd1292913986;
    localparam logic [51:0] ROUND_HALF       = 52'h0000080000000;
    localparam logic [17:0] NEG_LOG10_CLAMP  = 18'd196608;
    localparam logic [18:0] F5_BIAS          = 19'd393216;
    localparam logic [34:0] DRY_THRESHOLD    = 35'd8388608000;
    localparam logic [27:0] FLUX_K           = 28'd216172782;

    typedef struct packed {
        logic [15:0] wind_speed;
        logic [15:0] soil_wetness;
        logic [15:0] source_fraction;
        logic [47:0] prior_emission;
    } dfe_in_t;

    typedef struct packed {
        logic [47:0] new_emission;
        logic        emitted;
    } dfe_out_t;

    // per-stage load enables of the log10 unit
    typedef struct packed {
        logic st4;
        logic st3;
        logic st2;
        logic st1;
    } dfe_log_en_t;

    typedef logic [15:0] log_rom_t [LOG_TABLE_DEPTH];

    // log2(1 + k/depth) in Q16, truncated, by repeated squaring in Q30
    function automatic log_rom_t build_log2_rom();
        log_rom_t    rom;
        logic [63:0] x;
        logic [15:0] r;
        for (int k = 0; k < LOG_TABLE_DEPTH; k++) begin
            x = ((64'(LOG_TABLE_DEPTH) + 64'(k)) << 30) / 64'(LOG_TABLE_DEPTH);
            r = '0;
            for (int i = 15; i >= 0; i--) begin
                x = (x * x) >> 30;
                if (x >= 64'h0000_0000_8000_0000) begin
                    r[i] = 1'b1;
                    x    = x >> 1;
                end
            end
            rom[k] = r;
        end
        return rom;
    endfunction

    localparam log_rom_t LOG2_ROM = build_log2_rom();

endpackage

@@ rtl/dfe_log10.sv @@
module dfe_log10 (
    input  logic                aclk,
    input  dfe_pkg::dfe_log_en_t en,
    input  logic [15:0]         soil_wetness,
    output logic [18:0]         f5,
    output logic                wet
);

    // stage 1: classify, normalize, table index
    logic [3:0]                     msb_pos;
    logic [15:0]                    norm;
    logic [31:0]                    kprod;
    logic                           s1_small_reg;
    logic                           s1_wet_reg;
    logic [3:0]                     s1_msb_reg;
    logic [dfe_pkg::LOG_IDX_W-1:0]  s1_k_reg;

    always_comb begin
        msb_pos = '0;
        for (int i = 0; i < 16; i++) begin
            if (soil_wetness[i]) begin
                msb_pos = 4'(i);
            end
        end
        norm  = soil_wetness << (4'd15 - msb_pos);
        kprod = 32'(norm[14:0]) * 32'(dfe_pkg::LOG_TABLE_DEPTH);
    end

    // stage 2: negated log2, Q16
    logic [4:0]  int_part;
    logic [20:0] s2_n2_reg;
    logic        s2_small_reg;
    logic        s2_wet_reg;

    assign int_part = 5'd16 - {1'b0, s1_msb_reg};

    // stage 3: scale to log10
    logic [51:0] s3_prod_reg;
    logic        s3_small_reg;
    logic        s3_wet_reg;

    // stage 4: rounding and 5*factor
    logic [51:0] rounded;
    logic [17:0] n10;
    logic [18:0] s4_f5_reg;
    logic        s4_wet_reg;

    assign rounded = s3_prod_reg + dfe_pkg::ROUND_HALF;
    assign n10     = s3_small_reg ? dfe_pkg::NEG_LOG10_CLAMP : rounded[49:32];

    always_ff @(posedge aclk) begin
        if (en.st1) begin
            s1_small_reg <= soil_wetness < dfe_pkg::CLAMP_LIMIT;
            s1_wet_reg   <= soil_wetness <= dfe_pkg::WET_LIMIT;
            s1_msb_reg   <= msb_pos;
            s1_k_reg     <= kprod[15 +: dfe_pkg::LOG_IDX_W];
        end
        if (en.st2) begin
            s2_n2_reg    <= {int_part, 16'h0000} - 21'(dfe_pkg::LOG2_ROM[s1_k_reg]);
            s2_small_reg <= s1_small_reg;
            s2_wet_reg   <= s1_wet_reg;
        end
        if (en.st3) begin
            s3_prod_reg  <= 52'(s2_n2_reg) * 52'(dfe_pkg::LOG10_2_Q32);
            s3_small_reg <= s2_small_reg;
            s3_wet_reg   <= s2_wet_reg;
        end
        if (en.st4) begin
            s4_f5_reg  <= dfe_pkg::F5_BIAS - 19'(n10);
            s4_wet_reg <= s3_wet_reg;
        end
    end

    assign f5  = s4_f5_reg;
    assign wet = s4_wet_reg;

endmodule

@@ rtl/dust_emission_flux_cell.sv @@
// dust emission flux for one grid cell per request
//
// input channel (s_valid/s_ready/s_data): wind speed, wetness, source fraction
// and prior emission of one cell. result channel (m_valid/m_ready/m_data):
// new emission (saturating at 2^48-1) and the emitted flag.
// configuration: apb-style port, one 32-bit register at byte address 0,
// base_threshold in bits 15:0; pready is tied high, write only while idle.
//
// throughput: one request per cycle unless a stall on m_ready holds the
// pipeline, set by an 11-stage pipeline where no stage chains more than one
// multiplier (wind squared, source product, log10 scaling, threshold, energy
// term; stage 8 runs the two flux constant products side by side).
// reset (aresetn low, synchronous) empties the pipeline and loads the base
// threshold with 624 (2.4375 m/s).
// a stall on m_ready holds only the stages that are full; empty stages
// behind the output keep filling, so s_ready drops only once every stage
// holds a request. nothing is lost or repeated across a stall.
module dust_emission_flux_cell (
    input  logic             aclk,
    input  logic             aresetn,
    // request channel
    input  logic             s_valid,
    output logic             s_ready,
    input  dfe_pkg::dfe_in_t s_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output dfe_pkg::dfe_out_t m_data,
    // configuration port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // ---------------------------------------------------------------
    // configuration register
    // ---------------------------------------------------------------
    logic [15:0] base_threshold_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[2] == dfe_pkg::REG_IDX_BASE_THRESHOLD);
    assign prdata    = (paddr[2] == dfe_pkg::REG_IDX_BASE_THRESHOLD)
                       ? {16'h0000, base_threshold_reg} : 32'h0000_0000;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_threshold_reg <= dfe_pkg::BASE_THRESHOLD_RESET;
        end else if (cfg_write) begin
            base_threshold_reg <= pwdata[15:0];
        end
    end

    // ---------------------------------------------------------------
    // pipeline control: a stage loads when empty or when the next one loads
    // ---------------------------------------------------------------
    logic [11:1] valid_reg;
    logic [11:1] stage_en;

    always_comb begin
        stage_en[11] = !valid_reg[11] || m_ready;
        for (int i = 10; i >= 1; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    assign s_ready = stage_en[1];
    assign m_valid = valid_reg[11];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[1]) begin
                valid_reg[1] <= s_valid;
            end
            for (int i = 2; i <= 11; i++) begin
                if (stage_en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // threshold factor from wetness, stages 1 to 4
    // ---------------------------------------------------------------
    dfe_pkg::dfe_log_en_t log_en;
    logic [18:0]          log_f5;
    logic                 log_wet;

    assign log_en = '{st4: stage_en[4], st3: stage_en[3],
                      st2: stage_en[2], st1: stage_en[1]};

    dfe_log10 u_log10 (
        .aclk         (aclk),
        .en           (log_en),
        .soil_wetness (s_data.soil_wetness),
        .f5           (log_f5),
        .wet          (log_wet)
    );

    // ---------------------------------------------------------------
    // datapath
    // ---------------------------------------------------------------
    // wind in threshold units: wind * 5 * 2^16
    logic [34:0] speed_scaled;
    assign speed_scaled = {3'b000, s_data.wind_speed, 16'h0000}
                        + {1'b0, s_data.wind_speed, 18'h00000};

    logic [34:0] speed_reg [1:5];   // wind, threshold units
    logic [31:0] wind_sq_reg;       // stage 1: wind^2
    logic [15:0] source_reg;        // stage 1
    logic [31:0] b_reg [2:6];       // source weighted wind^2
    logic [47:0] prior_reg [1:10];
    logic [34:0] thr_reg;           // stage 5
    logic        hit_reg [6:10];
    logic [26:0] d8_reg;            // stage 6
    logic [58:0] energy_reg;        // stage 7
    logic [54:0] ph_reg;            // stage 8: high half times flux constant
    logic [59:0] pl_reg;            // stage 8: low half times flux constant
    logic [60:0] q_reg;             // stage 9
    logic [46:0] phs_reg;           // stage 9
    logic [47:0] flux_reg;          // stage 10
    dfe_pkg::dfe_out_t out_reg;     // stage 11

    logic [47:0] ab_prod;
    logic [34:0] excess;
    logic [60:0] q_next;
    logic [48:0] sum;

    assign ab_prod = 48'(wind_sq_reg) * 48'(source_reg);
    assign excess  = speed_reg[5] - thr_reg;
    assign q_next  = 61'({ph_reg[7:0], 32'h0000_0000}) + 61'(pl_reg);
    assign sum     = {1'b0, prior_reg[10]} + {1'b0, flux_reg};

    always_ff @(posedge aclk) begin
        // stage 1: scaled wind, wind squared, source fraction and prior emission
        if (stage_en[1]) begin
            speed_reg[1] <= speed_scaled;
            wind_sq_reg  <= 32'(s_data.wind_speed) * 32'(s_data.wind_speed);
            source_reg   <= s_data.source_fraction;
            prior_reg[1] <= s_data.prior_emission;
        end
        // stage 2: weight by source fraction
        if (stage_en[2]) begin
            b_reg[2] <= ab_prod[47:16];
        end
        for (int i = 2; i <= 5; i++) begin
            if (stage_en[i]) begin
                speed_reg[i] <= speed_reg[i-1];
            end
        end
        for (int i = 3; i <= 6; i++) begin
            if (stage_en[i]) begin
                b_reg[i] <= b_reg[i-1];
            end
        end
        for (int i = 2; i <= 10; i++) begin
            if (stage_en[i]) begin
                prior_reg[i] <= prior_reg[i-1];
            end
        end
        // stage 5: threshold, wet from table or fixed dry value
        if (stage_en[5]) begin
            thr_reg <= log_wet ? 35'(base_threshold_reg) * 35'(log_f5)
                               : dfe_pkg::DRY_THRESHOLD;
        end
        // stage 6: compare and excess wind
        if (stage_en[6]) begin
            hit_reg[6] <= speed_reg[5] > thr_reg;
            d8_reg     <= excess[34:8];
        end
        for (int i = 7; i <= 10; i++) begin
            if (stage_en[i]) begin
                hit_reg[i] <= hit_reg[i-1];
            end
        end
        // stage 7: energy term
        if (stage_en[7]) begin
            energy_reg <= 59'(b_reg[6]) * 59'(d8_reg);
        end
        // stage 8: flux constant, split in halves
        if (stage_en[8]) begin
            ph_reg <= 55'(dfe_pkg::FLUX_K) * 55'(energy_reg[58:32]);
            pl_reg <= 60'(dfe_pkg::FLUX_K) * 60'(energy_reg[31:0]);
        end
        // stage 9: merge the low byte of the high product
        if (stage_en[9]) begin
            q_reg   <= q_next;
            phs_reg <= ph_reg[54:8];
        end
        // stage 10: flux = product / 2^40
        if (stage_en[10]) begin
            flux_reg <= 48'(phs_reg) + 48'(q_reg[60:40]);
        end
        // stage 11: saturating add into the output register, or prior emission when no hit
        if (stage_en[11]) begin
            out_reg.emitted <= hit_reg[10];
            if (!hit_reg[10]) begin
                out_reg.new_emission <= prior_reg[10];
            end else if (sum[48]) begin
                out_reg.new_emission <= '1;
            end else begin
                out_reg.new_emission <= sum[47:0];
            end
        end
    end

    assign m_data = out_reg;

endmodule

@@ rtl/dfe_port_checker.sv @@
module dfe_port_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input dfe_pkg::dfe_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input dfe_pkg::dfe_out_t m_data,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [2:0]        paddr,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata,
    input logic              pready
);

    // pipeline comes up empty
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a free output stage must let requests in
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_ready || !m_valid) |-> s_ready)
        else $error("request refused while output can drain");

    // written threshold reads back
    assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready
         && (paddr[2] == dfe_pkg::REG_IDX_BASE_THRESHOLD))
        |=> ((paddr[2] != dfe_pkg::REG_IDX_BASE_THRESHOLD)
             || (prdata[15:0] == $past(pwdata[15:0]))))
        else $error("threshold readback mismatch");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed or dropped");

endmodule

bind dust_emission_flux_cell dfe_port_checker u_port_checker (.*);
